// ===== rtl/core/bbox_delta_decode_macros.svh =====
// ----------------------------------------------------------------------------
// bbox_delta_decode assertion macros
// shared concurrent assertion forms, all clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef BBOX_DELTA_DECODE_MACROS_SVH
`define BBOX_DELTA_DECODE_MACROS_SVH

// same-cycle implication, off while reset is held
`define BBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define BBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked around reset
`define BBD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd_pkg
// shared widths, constants and types of the box delta decoder
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int BATCH_SLOTS = 64;
    localparam int NUM_STAGES  = 10;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 80;
    localparam int CFG_W     = 64;

    // wide accumulator for corners in q.33
    localparam int ACC_W = 61;

    typedef logic [NUM_STAGES:1] t_stage_en;

    typedef enum logic [1:0] {
        CFG_MEANS   = 2'd0,
        CFG_STDS    = 2'd1,
        CFG_FILT_EN = 2'd2,
        CFG_MASK    = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] STDS_RESET = 64'h1000_1000_1000_1000;

    // 2^f polynomial, q.16
    localparam logic [15:0] EXP_C1 = 16'd45559;
    localparam logic [15:0] EXP_C2 = 16'd14820;
    localparam logic [15:0] EXP_C3 = 16'd5156;

    localparam logic signed [34:0] LOG2E_Q16 = 35'sd94548;
    localparam logic signed [21:0] CLAMP_HI  = 22'sd32768;
    localparam logic signed [21:0] CLAMP_LO  = -22'sd32768;

    localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] OUT_MIN = 20'sh80000;

    localparam logic signed [ACC_W-1:0] W_BIAS   = {{(ACC_W-33){1'b0}}, 1'b1, 32'd0};
    localparam logic signed [ACC_W-1:0] RND_HALF = {{(ACC_W-29){1'b0}}, 1'b1, 28'd0};
    localparam logic signed [ACC_W-1:0] SAT_LIM  = {{(ACC_W-49){1'b0}}, 1'b1, 48'd0};

endpackage

// ===== rtl/core/bbox_delta_decode.sv =====
// ----------------------------------------------------------------------------
// bbox_delta_decode
// region box regression delta decoder; unless full and stalled, one box per cycle
// ----------------------------------------------------------------------------
// s_axis carries one region box with its four q4.12 deltas per item; m_axis
// returns the four decoded, saturated corners. the config port writes the
// mean and std lanes, the batch filter enable and the batch mask; the user
// must write them only while idle, as the block does not enforce it. the
// pipeline has 10 register stages, with m_axis_tvalid as the last one's valid
// bit; the stages are denorm multiply, round and mean add, clamp with
// log2(e) multiply and center multiply, three horner stages of the 2^f
// polynomial, side * mantissa, exponent shift, corner add and round with saturation.
// throughput is one item per cycle unless a full pipeline is stalled. a box
// dropped by the batch filter is accepted and travels as a bubble, giving no result.
// each stage holds only while it carries a valid item and the stage ahead is
// held, so bubbles close up and input is still taken while a result waits on
// a stalled receiver; only a fully occupied pipeline drops s_axis_tready.
// reset clears all stage valid bits and sets the registers to their defaults
// (means zero, stds 1.0, filter off, mask clear).
// ----------------------------------------------------------------------------
module bbox_delta_decode
    import bbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // batch_index, roi_x1, roi_y1, roi_x2, roi_y2, delta_x, delta_y,
    // delta_w, delta_h, 2 zero pad bits
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // box_x1, box_y1, box_x2, box_y2
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // config registers
    logic [CFG_W-1:0] r_means;
    logic [CFG_W-1:0] r_stds;
    logic             r_filt_en;
    logic [CFG_W-1:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_means   <= '0;
            r_stds    <= STDS_RESET;
            r_filt_en <= 1'b0;
            r_mask    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MEANS:   r_means   <= i_cfg_data;
                CFG_STDS:    r_stds    <= i_cfg_data;
                CFG_FILT_EN: r_filt_en <= i_cfg_data[0];
                CFG_MASK:    r_mask    <= i_cfg_data;
            endcase
        end
    end

    // input fields
    logic [5:0]  batch_index;
    logic [15:0] roi_x1, roi_y1, roi_x2, roi_y2;
    logic [15:0] delta_x, delta_y, delta_w, delta_h;

    assign batch_index = s_axis_tdata[5:0];
    assign roi_x1      = s_axis_tdata[21:6];
    assign roi_y1      = s_axis_tdata[37:22];
    assign roi_x2      = s_axis_tdata[53:38];
    assign roi_y2      = s_axis_tdata[69:54];
    assign delta_x     = s_axis_tdata[85:70];
    assign delta_y     = s_axis_tdata[101:86];
    assign delta_w     = s_axis_tdata[117:102];
    assign delta_h     = s_axis_tdata[133:118];

    // batch filter: when enabled, index out of range or mask bit clear drops the box
    logic keep;
    assign keep = !r_filt_en ||
                  (({1'b0, batch_index} < 7'(BATCH_SLOTS)) && r_mask[batch_index]);

    // stage valid chain with bubble collapse
    logic [NUM_STAGES:1]   r_vld;
    logic [NUM_STAGES+1:1] en;
    t_stage_en             stage_en;

    always_comb begin
        en[NUM_STAGES+1] = m_axis_tready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        stage_en = en[NUM_STAGES:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= s_axis_tvalid && keep;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[1];
    assign m_axis_tvalid = r_vld[NUM_STAGES];

    // denormalized deltas, valid at stage 2
    logic signed [21:0] dn_x, dn_y, dn_w, dn_h;

    bbd_denorm u_dn_x (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_delta ($signed(delta_x)),
        .i_std   (r_stds[15:0]),
        .i_mean  (r_means[15:0]),
        .o_dn    (dn_x)
    );

    bbd_denorm u_dn_y (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_delta ($signed(delta_y)),
        .i_std   (r_stds[31:16]),
        .i_mean  (r_means[31:16]),
        .o_dn    (dn_y)
    );

    bbd_denorm u_dn_w (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_delta ($signed(delta_w)),
        .i_std   (r_stds[47:32]),
        .i_mean  (r_means[47:32]),
        .o_dn    (dn_w)
    );

    bbd_denorm u_dn_h (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_delta ($signed(delta_h)),
        .i_std   (r_stds[63:48]),
        .i_mean  (r_means[63:48]),
        .o_dn    (dn_h)
    );

    // per-axis corner decode
    logic signed [19:0] box_x1, box_y1, box_x2, box_y2;

    bbd_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_lo     (roi_x1),
        .i_hi     (roi_x2),
        .i_dc     (dn_x),
        .i_dl     (dn_w),
        .o_first  (box_x1),
        .o_second (box_x2)
    );

    bbd_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_lo     (roi_y1),
        .i_hi     (roi_y2),
        .i_dc     (dn_y),
        .i_dl     (dn_h),
        .o_first  (box_y1),
        .o_second (box_y2)
    );

    assign m_axis_tdata = {box_y2, box_x2, box_y1, box_x1};

endmodule

// ===== rtl/core/bbd_denorm.sv =====
// ----------------------------------------------------------------------------
// bbd_denorm
// two-stage delta denormalization: delta * std, round to q.12, add mean
// ----------------------------------------------------------------------------
module bbd_denorm
    import bbd_pkg::*;
(
    input  logic               i_clk,
    input  t_stage_en          i_en,
    input  logic signed [15:0] i_delta,
    input  logic [15:0]        i_std,
    input  logic [15:0]        i_mean,
    output logic signed [21:0] o_dn
);

    logic signed [32:0] r_p;
    logic signed [32:0] n_p;
    logic signed [32:0] rnd;
    logic signed [21:0] r_dn;
    logic signed [21:0] n_dn;

    always_comb begin
        n_p  = $signed(i_delta) * $signed({1'b0, i_std});
        rnd  = r_p + 33'sd2048;
        n_dn = 22'(rnd >>> 12) + 22'($signed(i_mean));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_p <= n_p;
        end
        if (i_en[2]) begin
            r_dn <= n_dn;
        end
    end

    assign o_dn = r_dn;

endmodule

// ===== rtl/core/bbd_exp2.sv =====
// ----------------------------------------------------------------------------
// bbd_exp2
// three-stage horner evaluation of 2^f in q.16, one multiply per stage
// ----------------------------------------------------------------------------
module bbd_exp2
    import bbd_pkg::*;
(
    input  logic        i_clk,
    input  t_stage_en   i_en,
    input  logic [15:0] i_f,
    output logic [16:0] o_m
);

    logic [28:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [15:0] r_t1;
    logic [15:0] r_t2;
    logic [16:0] r_m;
    logic [15:0] r_f4;
    logic [15:0] r_f5;

    always_comb begin
        p4 = {13'd0, EXP_C3} * {13'd0, i_f};
        p5 = {16'd0, r_t1} * {16'd0, r_f4};
        p6 = {16'd0, r_t2} * {16'd0, r_f5};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_t1 <= {3'd0, p4[28:16]} + EXP_C2;
            r_f4 <= i_f;
        end
        if (i_en[5]) begin
            r_t2 <= p5[31:16] + EXP_C1;
            r_f5 <= r_f4;
        end
        if (i_en[6]) begin
            r_m <= {1'b0, p6[31:16]} + 17'h10000;
        end
    end

    assign o_m = r_m;

endmodule

// ===== rtl/core/bbd_axis.sv =====
// ----------------------------------------------------------------------------
// bbd_axis
// one axis of the decode: side, center shift, exp scale, corners, saturate
// ----------------------------------------------------------------------------
module bbd_axis
    import bbd_pkg::*;
(
    input  logic               i_clk,
    input  t_stage_en          i_en,
    input  logic [15:0]        i_lo,
    input  logic [15:0]        i_hi,
    input  logic signed [21:0] i_dc,
    input  logic signed [21:0] i_dl,
    output logic signed [19:0] o_first,
    output logic signed [19:0] o_second
);

    function automatic logic signed [19:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] s;
        r = v + RND_HALF;
        s = r >>> 29;
        if (r >= SAT_LIM) begin
            return OUT_MAX;
        end else if (r < -SAT_LIM) begin
            return OUT_MIN;
        end else begin
            return s[19:0];
        end
    endfunction

    // stage 1..2: side and a + b - 16
    logic signed [17:0] r_side1, r_side2, r_side3, r_side4, r_side5, r_side6;
    logic signed [17:0] r_sum1, r_sum2, r_sum3, r_sum4, r_sum5, r_sum6;
    logic signed [16:0] dlc;
    logic signed [34:0] r_y3;
    logic signed [39:0] r_pcp3, r_pcp4, r_pcp5, r_pcp6;
    logic signed [6:0]  n_int;
    logic [4:0]         n_sh;
    logic [4:0]         r_sh4, r_sh5, r_sh6, r_sh7;
    logic [16:0]        m;
    logic signed [35:0] r_sm7;
    logic signed [ACC_W-1:0] r_pc7;
    logic signed [ACC_W-1:0] r_w8;
    logic signed [ACC_W-1:0] r_pc8;
    logic signed [ACC_W-1:0] r_v1;
    logic signed [ACC_W-1:0] r_v2;
    logic signed [19:0] r_o1;
    logic signed [19:0] r_o2;

    always_comb begin
        if (i_dl > CLAMP_HI) begin
            dlc = 17'sd32768;
        end else if (i_dl < CLAMP_LO) begin
            dlc = -17'sd32768;
        end else begin
            dlc = 17'(i_dl);
        end
        n_int = r_y3[34:28];
        n_sh  = 5'(n_int + 7'sd12);
    end

    bbd_exp2 u_exp2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_f   (r_y3[27:12]),
        .o_m   (m)
    );

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_side1 <= $signed({2'b00, i_hi}) - $signed({2'b00, i_lo}) + 18'sd16;
            r_sum1  <= $signed({2'b00, i_hi}) + $signed({2'b00, i_lo}) - 18'sd16;
        end
        if (i_en[2]) begin
            r_side2 <= r_side1;
            r_sum2  <= r_sum1;
        end
        if (i_en[3]) begin
            r_y3    <= 35'(dlc) * LOG2E_Q16;
            r_pcp3  <= 40'(i_dc) * 40'(r_side2);
            r_side3 <= r_side2;
            r_sum3  <= r_sum2;
        end
        if (i_en[4]) begin
            r_sh4   <= n_sh;
            r_pcp4  <= r_pcp3;
            r_side4 <= r_side3;
            r_sum4  <= r_sum3;
        end
        if (i_en[5]) begin
            r_sh5   <= r_sh4;
            r_pcp5  <= r_pcp4;
            r_side5 <= r_side4;
            r_sum5  <= r_sum4;
        end
        if (i_en[6]) begin
            r_sh6   <= r_sh5;
            r_pcp6  <= r_pcp5;
            r_side6 <= r_side5;
            r_sum6  <= r_sum5;
        end
        if (i_en[7]) begin
            r_sm7 <= 36'(r_side6) * $signed({19'd0, m});
            r_pc7 <= (ACC_W'(r_pcp6) <<< 16) + (ACC_W'(r_sum6) <<< 27);
            r_sh7 <= r_sh6;
        end
        if (i_en[8]) begin
            // side * exp(dl) in q.32, minus one pixel
            r_w8  <= (ACC_W'(r_sm7) <<< r_sh7) - W_BIAS;
            r_pc8 <= r_pc7 <<< 1;
        end
        if (i_en[9]) begin
            r_v1 <= r_pc8 - r_w8;
            r_v2 <= r_pc8 + r_w8;
        end
        if (i_en[10]) begin
            r_o1 <= round_sat(r_v1);
            r_o2 <= round_sat(r_v2);
        end
    end

    assign o_first  = r_o1;
    assign o_second = r_o2;

endmodule

// ===== rtl/core/bbd_checker.sv =====
// ----------------------------------------------------------------------------
// bbd_checker
// port-level assertions for the box delta decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "bbox_delta_decode_macros.svh"

module bbd_checker
    import bbd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result stays offered
    `BBD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // a stalled result keeps its corners
    `BBD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // input backs up only when the output is held
    `BBD_ASSERT_NOW(a_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

    // reset empties the pipeline
    `BBD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !m_axis_tvalid, "result offered right after reset")

endmodule

bind bbox_delta_decode bbd_checker u_bbd_checker (.*);

// ===== tb/bbd_box_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbd_box_checker
// watches the box decoder's streams and config port, predicts every decoded
// box from its own register copy and compares results in order
// ----------------------------------------------------------------------------
module bbd_box_checker
    import bbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);

    localparam logic [CFG_W-1:0] IDENTITY_STDS = 64'h1000_1000_1000_1000;
    localparam longint CLAMP_LOG = 32768;
    localparam longint LOG2E     = 94548;
    localparam longint unsigned POLY_C1 = 45559;
    localparam longint unsigned POLY_C2 = 14820;
    localparam longint unsigned POLY_C3 = 5156;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [5:0]         batch;
        logic [15:0]        x1, y1, x2, y2;
        logic signed [15:0] dx, dy, dw, dh;
    } t_region;

    // x1 in the lowest bits
    typedef struct packed {
        logic signed [19:0] y2, x2, y1, x1;
    } t_corners;

    logic [CFG_W-1:0] means_r, stds_r, mask_r;
    logic             filt_on;
    t_corners         expected_boxes[$];
    int               err_cnt = 0;
    int               box_cnt = 0;

    function automatic longint denorm_delta(input logic signed [15:0] d, input int lane);
        longint prod;
        prod = longint'(d) * longint'(stds_r[16*lane +: 16]);
        return ((prod + 2048) >>> 12) + longint'($signed(means_r[16*lane +: 16]));
    endfunction

    // side (q.4) times exp(dl), dl in q.12, result in q.32
    function automatic longint scaled_side(input longint side, input longint dl);
        longint v, u, n;
        longint unsigned f, m;
        v = (dl > CLAMP_LOG) ? CLAMP_LOG : ((dl < -CLAMP_LOG) ? -CLAMP_LOG : dl);
        u = v * LOG2E + (64'sd16 <<< 28);
        n = (u >>> 28) - 16;
        f = (u >>> 12) & 64'hFFFF;
        m = POLY_C3;
        m = ((m * f) >> 16) + POLY_C2;
        m = ((m * f) >> 16) + POLY_C1;
        m = ((m * f) >> 16) + 65536;
        return side * longint'(m) * (64'sd1 <<< (n + 12));
    endfunction

    // q.33 rounded half up to q.4, saturated to 20 bits
    function automatic logic signed [19:0] round_sat(input longint v);
        longint r;
        r = v + (64'sd1 <<< 28);
        if (r >= (64'sd1 <<< 48))
            return 20'sh7FFFF;
        else if (r < -(64'sd1 <<< 48))
            return 20'sh80000;
        else
            return 20'(r >>> 29);
    endfunction

    function automatic void decode_axis(input logic [15:0] lo, input logic [15:0] hi,
                                        input longint dc, input longint dl,
                                        output logic signed [19:0] c1,
                                        output logic signed [19:0] c2);
        longint a, b, side, ctr, pc, w;
        a    = longint'(lo);
        b    = longint'(hi);
        side = b - a + 16;
        ctr  = (2 * a + side - 32) <<< 27;
        pc   = dc * side * (64'sd1 <<< 16) + ctr;
        w    = scaled_side(side, dl) - (64'sd1 <<< 32);
        c1   = round_sat(2 * pc - w);
        c2   = round_sat(2 * pc + w);
    endfunction

    // returns 0 when the batch filter drops the box
    function automatic bit decode_box(input t_region r, output t_corners c);
        longint dxn, dyn, dwn, dhn;
        if (filt_on && (int'(r.batch) >= BATCH_SLOTS || !mask_r[r.batch]))
            return 1'b0;
        dxn = denorm_delta(r.dx, 0);
        dyn = denorm_delta(r.dy, 1);
        dwn = denorm_delta(r.dw, 2);
        dhn = denorm_delta(r.dh, 3);
        decode_axis(r.x1, r.x2, dxn, dwn, c.x1, c.x2);
        decode_axis(r.y1, r.y2, dyn, dhn, c.y1, c.y2);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_region  reg_in;
        t_corners want, got;
        if (!i_rst_n) begin
            means_r = '0;
            stds_r  = IDENTITY_STDS;
            filt_on = 1'b0;
            mask_r  = '0;
            expected_boxes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MEANS:   means_r = i_cfg_data;
                    CFG_STDS:    stds_r  = i_cfg_data;
                    CFG_FILT_EN: filt_on = i_cfg_data[0];
                    CFG_MASK:    mask_r  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                reg_in.batch = i_s_tdata[5:0];
                reg_in.x1    = i_s_tdata[21:6];
                reg_in.y1    = i_s_tdata[37:22];
                reg_in.x2    = i_s_tdata[53:38];
                reg_in.y2    = i_s_tdata[69:54];
                reg_in.dx    = i_s_tdata[85:70];
                reg_in.dy    = i_s_tdata[101:86];
                reg_in.dw    = i_s_tdata[117:102];
                reg_in.dh    = i_s_tdata[133:118];
                // queued at the tail, taken from the head in arrival order
                if (decode_box(reg_in, want))
                    expected_boxes.insert(expected_boxes.size(), want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_corners'(i_m_tdata);
                box_cnt++;
                if (expected_boxes.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected box %0d: x1=%0d y1=%0d x2=%0d y2=%0d",
                                 box_cnt, got.x1, got.y1, got.x2, got.y2);
                end else begin
                    want = expected_boxes.pop_front();
                    if (got.x1 !== want.x1 || got.y1 !== want.y1 ||
                        got.x2 !== want.x2 || got.y2 !== want.y2) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("box %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     box_cnt, want.x1, want.y1, want.x2, want.y2,
                                     got.x1, got.y1, got.x2, got.y2);
                    end
                end
            end
        end
        o_pending <= expected_boxes.size();
        o_errors  <= err_cnt;
        o_checked <= box_cnt;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the box delta decoder
// ----------------------------------------------------------------------------
// drives region boxes in random bursts through several register settings,
// while the receiver stalls on its own schedule; the checker module beside
// the decoder predicts and compares every decoded box
// ----------------------------------------------------------------------------
module tb;
    import bbd_pkg::*;

    localparam int DRAIN_CYCLES = 24;     // pipeline is 10 deep, plus margin
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;    // receiver hold-off to fill the pipe
    localparam int LOOP_PHASES  = 8;
    localparam int PHASE_ITEMS  = 140;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [1:0]           cfg_index = CFG_MEANS;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 hold_req = 1'b0;

    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    int errors, pending, checked;
    int cycles     = 0;
    int sent       = 0;
    int settings   = 1;
    int burst_left = 0;
    int hold_left  = 0;
    int mode_left  = 0;
    int stall_pct  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bbox_delta_decode i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    bbd_box_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d boxes still expected", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: long hold-off on request, else stall density changes in stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;      // no stalling at all
                    1: stall_pct = 10;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            mode_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // tdata: batch_index, roi_x1, roi_y1, roi_x2, roi_y2, dx, dy, dw, dh, pad
    function automatic logic [S_TDATA_W-1:0] pack_box(
        input logic [5:0] bi, input logic [15:0] x1, input logic [15:0] y1,
        input logic [15:0] x2, input logic [15:0] y2, input logic [15:0] dx,
        input logic [15:0] dy, input logic [15:0] dw, input logic [15:0] dh);
        return {2'b00, dh, dw, dy, dx, y2, x2, y1, x1, bi};
    endfunction

    // delta within +/-1.0
    function automatic logic [15:0] small_delta();
        return 16'($urandom_range(0, 8192)) - 16'd4096;
    endfunction

    function automatic logic [15:0] big_log();
        case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(16'h6000, 16'h7FFF));
            default: return 16'($urandom_range(16'h8000, 16'hA000));
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_box();
        logic [5:0]  bi;
        logic [15:0] x1, y1, x2, y2;
        int          kind;
        bi   = 6'($urandom_range(0, 63));
        kind = $urandom_range(0, 99);
        x1   = 16'($urandom_range(0, 60000));
        y1   = 16'($urandom_range(0, 60000));
        if (kind < 55) begin
            // ordinary proposal with modest deltas
            x2 = 16'((int'(x1) + $urandom_range(0, 4000) > 65535) ? 65535
                                                  : int'(x1) + $urandom_range(0, 4000));
            y2 = 16'((int'(y1) + $urandom_range(0, 4000) > 65535) ? 65535
                                                  : int'(y1) + $urandom_range(0, 4000));
            return pack_box(bi, x1, y1, x2, y2, small_delta(), small_delta(),
                            small_delta(), small_delta());
        end else if (kind < 80) begin
            return pack_box(bi, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (kind < 92) begin
            // inverted corners
            x2 = 16'($urandom_range(0, x1));
            y2 = 16'($urandom_range(0, y1));
            return pack_box(bi, x1, y1, x2, y2, small_delta(), small_delta(),
                            small_delta(), small_delta());
        end else begin
            return pack_box(bi, x1, y1, 16'($urandom), 16'($urandom), small_delta(),
                            small_delta(), big_log(), big_log());
        end
    endfunction

    // offers one item, opening a new burst after a random gap when needed
    task automatic send_box(input logic [S_TDATA_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
        sent++;
    endtask

    // stop offering, wait for every expected box, then let dropped items drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] means, input logic [CFG_W-1:0] stds,
                             input logic [CFG_W-1:0] filt, input logic [CFG_W-1:0] mask);
        write_reg(CFG_MEANS, means);
        write_reg(CFG_STDS, stds);
        write_reg(CFG_FILT_EN, filt);
        write_reg(CFG_MASK, mask);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    function automatic logic [CFG_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // lanes between 0.5 and 1.5
    function automatic logic [CFG_W-1:0] modest_stds();
        return {16'($urandom_range(16'h0800, 16'h1800)), 16'($urandom_range(16'h0800, 16'h1800)),
                16'($urandom_range(16'h0800, 16'h1800)), 16'($urandom_range(16'h0800, 16'h1800))};
    endfunction

    initial begin : stimulus
        logic [CFG_W-1:0] p_means, p_stds, p_filt, p_mask;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: identity normalization, filter off
        send_box(pack_box(6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_box(pack_box(6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_box(pack_box(6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // full-frame box
        send_box(pack_box(6'd21, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // inverted corners, negative width used as is
        send_box(pack_box(6'd42, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                          16'h1000, 16'hF000, 16'h0000, 16'h0000));
        // huge scale, corners saturate on both sides
        send_box(pack_box(6'd5, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                          16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF));
        send_box(pack_box(6'd6, 16'h8000, 16'h8000, 16'h8010, 16'h8010,
                          16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        send_box(pack_box(6'd7, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
                          16'h0800, 16'hF800, 16'h1000, 16'hF000));
        // single lsb deltas, rounding edges
        send_box(pack_box(6'd63, 16'h1234, 16'h5678, 16'h1334, 16'h5778,
                          16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF));
        // zero side: x2 one pixel left of x1
        send_box(pack_box(6'd1, 16'h0010, 16'h0010, 16'h0000, 16'h0000,
                          16'h0400, 16'h0400, 16'h0400, 16'h0400));
        settle();

        // stds 2.0 so the log clamp at +/-8.0 is reachable; upper enable bits ignored
        load_regs(64'h0, 64'h2000_2000_2000_2000, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0);
        send_box(pack_box(6'd2, 16'h1000, 16'h1000, 16'h1100, 16'h1100,
                          16'h0000, 16'h0000, 16'h4000, 16'hC000));
        send_box(pack_box(6'd3, 16'h1000, 16'h1000, 16'h1100, 16'h1100,
                          16'h0000, 16'h0000, 16'h4001, 16'hBFFF));
        send_box(pack_box(6'd4, 16'h2000, 16'h2000, 16'h2040, 16'h2040,
                          16'h0000, 16'h0000, 16'h7FFF, 16'h8000));
        send_box(pack_box(6'd8, 16'h4000, 16'h4000, 16'h5000, 16'h5000,
                          16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
        settle();

        // extreme means and stds, filter keeps only batch 0 and 63
        load_regs(64'h7FFF_8000_7FFF_8000, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
        send_box(pack_box(6'd0, 16'h0800, 16'h0800, 16'h0900, 16'h0900,
                          16'h0100, 16'hFF00, 16'h0100, 16'hFF00));
        send_box(pack_box(6'd63, 16'h0800, 16'h0800, 16'h0900, 16'h0900,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_box(pack_box(6'd1, 16'h0800, 16'h0800, 16'h0900, 16'h0900,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_box(pack_box(6'd62, 16'h0800, 16'h0800, 16'h0900, 16'h0900,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_box(pack_box(6'd32, 16'h0800, 16'h0800, 16'h0900, 16'h0900,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
        repeat (120) send_box(random_box());
        settle();

        // random settings, with the stds-zero and mask-all-ones extremes
        for (int k = 0; k < LOOP_PHASES; k++) begin
            p_means = (k == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : ((k % 2 == 0) ? rand64() : 64'h0);
            p_stds  = (k == 0) ? 64'h0 : ((k == 2) ? rand64() : modest_stds());
            p_filt  = rand64();
            if (k % 2 == 1)
                p_filt[0] = 1'b1;
            p_mask  = (k == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64();
            load_regs(p_means, p_stds, p_filt, p_mask);
            if (k == 1) begin
                // receiver holds off long enough that the pipe fills and stalls input
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (k == 3 && i == PHASE_ITEMS / 2)
                    settle();
                send_box(random_box());
            end
            settle();
        end

        // filter on with an empty mask drops everything
        load_regs(64'h0, STDS_RESET, 64'h1, 64'h0);
        repeat (16) send_box(random_box());
        settle();

        // back to identity, filter off
        load_regs(64'h0, STDS_RESET, 64'h0, rand64());
        repeat (100) send_box(random_box());
        settle();

        $display("sent %0d boxes over %0d register settings, %0d decoded boxes checked",
                 sent, settings, checked);
        $display("covered filter drops, log clamps, inverted and saturating boxes under stalls");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
